// ----- rtl/core/cst_pkg.sv -----
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types, constants and character helpers for the character stream
// tokenizer: token kinds, scanner modes and the front-to-back queue entry.
// ----------------------------------------------------------------------------
package cst_pkg;

  // Source size bound and the resulting saturation point of the byte offset
  localparam longint unsigned SOURCE_BYTES = 64'd65536;
  localparam logic [15:0] POS_MAX =
    ((SOURCE_BYTES - 64'd1) > 64'd65535) ? 16'hFFFF : 16'(SOURCE_BYTES - 64'd1);

  localparam int unsigned VALUE_W = 63;
  localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};
  localparam logic [15:0] LEN_MAX = 16'hFFFF;

  // Queue between scanner and output stage
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Token kinds as seen on the result channel
  typedef enum logic [3:0] {
    KIND_EOF    = 4'd0,
    KIND_INT    = 4'd1,
    KIND_IDENT  = 4'd2,
    KIND_RETURN = 4'd3,
    KIND_LET    = 4'd4,
    KIND_PLUS   = 4'd5,
    KIND_MINUS  = 4'd6,
    KIND_STAR   = 4'd7,
    KIND_SLASH  = 4'd8,
    KIND_ASSIGN = 4'd9,
    KIND_LPAREN = 4'd10,
    KIND_RPAREN = 4'd11,
    KIND_SEMI   = 4'd12,
    KIND_LBRACE = 4'd13,
    KIND_RBRACE = 4'd14,
    KIND_ERROR  = 4'd15
  } token_kind_t;

  // Scanner mode
  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_NUM   = 2'd1,
    MODE_IDENT = 2'd2
  } scan_mode_t;

  typedef struct packed {
    token_kind_t        kind;
    logic [VALUE_W-1:0] value;
    logic [15:0]        start;
    logic [15:0]        len;
  } token_t;

  // One queue entry holds every token that a single byte produces
  typedef struct packed {
    token_t first;
    token_t second;
    logic   two;
  } entry_t;

  // Character classes
  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_ident_first(input logic [7:0] c);
    return is_alpha(c) || (c == 8'h5F);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
  endfunction

  // Keyword spellings, one character per index
  function automatic logic [7:0] kw_return_char(input logic [2:0] idx);
    logic [7:0] r;
    unique case (idx)
      3'd0:    r = 8'h72; // r
      3'd1:    r = 8'h65; // e
      3'd2:    r = 8'h74; // t
      3'd3:    r = 8'h75; // u
      3'd4:    r = 8'h72; // r
      3'd5:    r = 8'h6E; // n
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] kw_let_char(input logic [1:0] idx);
    logic [7:0] r;
    unique case (idx)
      2'd0:    r = 8'h6C; // l
      2'd1:    r = 8'h65; // e
      2'd2:    r = 8'h74; // t
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // Operator decode; anything unknown maps to the error kind
  function automatic token_kind_t op_kind(input logic [7:0] c);
    token_kind_t k;
    unique case (c)
      8'h2B:   k = KIND_PLUS;
      8'h2D:   k = KIND_MINUS;
      8'h2A:   k = KIND_STAR;
      8'h2F:   k = KIND_SLASH;
      8'h3D:   k = KIND_ASSIGN;
      8'h28:   k = KIND_LPAREN;
      8'h29:   k = KIND_RPAREN;
      8'h3B:   k = KIND_SEMI;
      8'h7B:   k = KIND_LBRACE;
      8'h7D:   k = KIND_RBRACE;
      default: k = KIND_ERROR;
    endcase
    return k;
  endfunction

endpackage

// ----- rtl/core/cst_if.sv -----
// ----------------------------------------------------------------------------
// cst_if
// Valid/ready channel interfaces: source bytes in, tokens out.
// ----------------------------------------------------------------------------
interface cst_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface cst_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [62:0] int_value;
  logic [15:0] start_pos;
  logic [15:0] token_length;
  logic        last_of_run;

  modport source (output valid, output token_kind, output int_value, output start_pos,
                  output token_length, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input int_value, input start_pos,
                  input token_length, input last_of_run, output ready);
endinterface

// ----- rtl/core/cst_front.sv -----
// ----------------------------------------------------------------------------
// cst_front
// Scanner: accepts one byte per cycle while the queue has room, classifies it,
// tracks the pending token and pushes the tokens the byte completes as one queue entry.
// ----------------------------------------------------------------------------
module cst_front import cst_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_ch,
  output logic       push,
  output entry_t     push_entry,
  input  logic       push_ready
);

  scan_mode_t         mode, mode_next;
  logic [VALUE_W-1:0] accum, accum_next;
  logic [15:0]        start, start_next;
  logic [15:0]        len, len_next;
  logic [15:0]        pos, pos_next;
  logic [1:0]         flags, flags_next;
  logic               halted, halted_next;

  logic               accept;
  logic               digit, ident_more, ident_first;
  logic [3:0]         dval;
  logic [VALUE_W+3:0] mac;
  logic [VALUE_W-1:0] accum_dig;
  logic [15:0]        len_inc;
  logic [1:0]         flags_trk;
  token_t             flush_tok, emit_tok;
  logic               have_flush, emit_valid;

  assign in_ready = push_ready;
  assign accept   = in_valid && push_ready;

  // Byte classification
  assign digit       = is_digit(in_ch);
  assign ident_first = is_ident_first(in_ch);
  assign ident_more  = ident_first || digit;
  assign dval        = 4'(in_ch - 8'h30);

  // Saturating value*10 + digit, done as shifts and adds
  assign mac = ({4'b0, accum} << 3) + ({4'b0, accum} << 1) + {{VALUE_W{1'b0}}, dval};
  assign accum_dig = (mac > {4'b0, VALUE_MAX}) ? VALUE_MAX : mac[VALUE_W-1:0];

  assign len_inc = (len != LEN_MAX) ? len + 16'd1 : len;

  // Keyword candidates after this byte lands at index len
  always_comb begin
    flags_trk = flags;
    if (len >= 16'd6 || kw_return_char(len[2:0]) != in_ch) flags_trk[0] = 1'b0;
    if (len >= 16'd3 || kw_let_char(len[1:0]) != in_ch)    flags_trk[1] = 1'b0;
  end

  // Token that ends if this byte does not continue it
  always_comb begin
    flush_tok       = '0;
    flush_tok.start = start;
    flush_tok.len   = len;
    if (mode == MODE_NUM) begin
      flush_tok.kind  = KIND_INT;
      flush_tok.value = accum;
    end else if (flags[0] && len == 16'd6) begin
      flush_tok.kind = KIND_RETURN;
    end else if (flags[1] && len == 16'd3) begin
      flush_tok.kind = KIND_LET;
    end else begin
      flush_tok.kind = KIND_IDENT;
    end
  end

  // Scanner next state and queue push
  always_comb begin
    mode_next   = mode;
    accum_next  = accum;
    start_next  = start;
    len_next    = len;
    pos_next    = pos;
    flags_next  = flags;
    halted_next = halted;
    have_flush  = 1'b0;
    emit_valid  = 1'b0;
    emit_tok    = '0;
    emit_tok.start = pos;
    push        = 1'b0;
    push_entry  = '0;

    if (accept && !halted) begin
      if (mode == MODE_NUM && digit) begin
        accum_next = accum_dig;
        len_next   = len_inc;
      end else if (mode == MODE_IDENT && ident_more) begin
        flags_next = flags_trk;
        len_next   = len_inc;
      end else begin
        have_flush = (mode == MODE_NUM) || (mode == MODE_IDENT);
        mode_next  = MODE_IDLE;
        if (is_space(in_ch)) begin
          // skipped
        end else if (digit) begin
          mode_next  = MODE_NUM;
          start_next = pos;
          len_next   = 16'd1;
          accum_next = {{(VALUE_W-4){1'b0}}, dval};
          flags_next = 2'b11;
        end else if (ident_first) begin
          mode_next  = MODE_IDENT;
          start_next = pos;
          len_next   = 16'd1;
          accum_next = '0;
          flags_next = {in_ch == kw_let_char(2'd0), in_ch == kw_return_char(3'd0)};
        end else if (in_ch == 8'h00) begin
          emit_valid    = 1'b1;
          emit_tok.kind = KIND_EOF;
        end else begin
          emit_valid    = 1'b1;
          emit_tok.kind = op_kind(in_ch);
          if (op_kind(in_ch) == KIND_ERROR) halted_next = 1'b1;
        end
      end

      // Offset of the next byte; end of source restarts counting
      if (in_ch == 8'h00 && !(mode == MODE_IDENT && ident_more)
          && !(mode == MODE_NUM && digit)) begin
        pos_next = '0;
      end else if (pos < POS_MAX) begin
        pos_next = pos + 16'd1;
      end

      push = have_flush || emit_valid;
      if (have_flush) begin
        push_entry.first  = flush_tok;
        push_entry.second = emit_tok;
        push_entry.two    = emit_valid;
      end else begin
        push_entry.first  = emit_tok;
        push_entry.two    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_IDLE;
      accum  <= '0;
      start  <= '0;
      len    <= '0;
      pos    <= '0;
      flags  <= 2'b11;
      halted <= 1'b0;
    end else begin
      mode   <= mode_next;
      accum  <= accum_next;
      start  <= start_next;
      len    <= len_next;
      pos    <= pos_next;
      flags  <= flags_next;
      halted <= halted_next;
    end
  end

endmodule

// ----- rtl/core/cst_queue.sv -----
// ----------------------------------------------------------------------------
// cst_queue
// Short FIFO of token entries between the scanner and the output stage.
// ----------------------------------------------------------------------------
module cst_queue import cst_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   push_ready,
  output logic   head_valid,
  output entry_t head,
  input  logic   pop
);

  entry_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_push, do_pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_entry;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (!do_push && do_pop) count <= count - 1'b1;
    end
  end

endmodule

// ----- rtl/core/cst_back.sv -----
// ----------------------------------------------------------------------------
// cst_back
// Output stage: splits each queue entry into single tokens and holds the
// current token in an output register until the receiver takes it.
// ----------------------------------------------------------------------------
module cst_back import cst_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   head_valid,
  input  entry_t head,
  output logic   pop,
  output logic   out_valid,
  input  logic   out_ready,
  output token_t out_tok,
  output logic   out_last
);

  logic   sub;
  logic   load;
  logic   last_sel;
  token_t sel_tok;

  // Pick the token of the head entry that goes next
  assign load     = !out_valid || out_ready;
  assign sel_tok  = sub ? head.second : head.first;
  assign last_sel = sub || !head.two;
  assign pop      = load && head_valid && last_sel;

  // Control: valid flag and position inside the entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sub       <= 1'b0;
    end else if (load) begin
      out_valid <= head_valid;
      if (head_valid) sub <= !last_sel;
    end
  end

  // Payload register
  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      out_tok  <= sel_tok;
      out_last <= last_sel;
    end
  end

endmodule

// ----- rtl/core/char_stream_tokenizer_core.sv -----
// ----------------------------------------------------------------------------
// char_stream_tokenizer_core
// Byte-stream lexer: whitespace skip, saturating integers, identifiers with
// keyword match, single-character operators, EOF and error tokens.
// ----------------------------------------------------------------------------
// Usage:
//   src carries one source byte per item; a zero byte ends the source, emits
//   EOF and restarts byte offsets at zero. tok carries one token per item;
//   last_of_run marks the final token caused by a given byte.
//   Throughput: one byte per cycle while the queue has room. A byte that
//   ends a pending token and is itself a token yields two tokens, which leave
//   one per cycle through the output register while tok is ready; the scanner
//   keeps taking bytes meanwhile. With the queue empty, the combinational
//   scanner writes the entry at the edge that accepts the byte; the output
//   register then loads the token from the queue head and drives tok. The
//   second token of a pair is loaded from the same entry when the first is
//   taken. When tok stalls, the four-entry queue fills and src.ready drops;
//   nothing is lost. After an unrecognized byte the error token is emitted
//   and the block swallows further bytes without output until reset.
//   Reset (rst, synchronous) empties the queue and output register and puts
//   the scanner between tokens at offset zero.
// ----------------------------------------------------------------------------
module char_stream_tokenizer_core import cst_pkg::*; (
  input logic       clk,
  input logic       rst,
  cst_in_if.sink    src,
  cst_out_if.source tok
);

  logic   push, push_ready;
  entry_t push_entry;
  logic   head_valid, pop;
  entry_t head;
  token_t out_tok;
  logic   out_last;

  // Scanner
  cst_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (src.valid),
    .in_ready   (src.ready),
    .in_ch      (src.ch),
    .push       (push),
    .push_entry (push_entry),
    .push_ready (push_ready)
  );

  // Decoupling queue
  cst_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  // Output stage
  cst_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (tok.valid),
    .out_ready  (tok.ready),
    .out_tok    (out_tok),
    .out_last   (out_last)
  );

  assign tok.token_kind   = out_tok.kind;
  assign tok.int_value    = out_tok.value;
  assign tok.start_pos    = out_tok.start;
  assign tok.token_length = out_tok.len;
  assign tok.last_of_run  = out_last;

endmodule

// ----- tb/sv/char_stream_tokenizer_core_tb.sv -----
// ----------------------------------------------------------------------------
// char_stream_tokenizer_core_tb
// Self-checking bench for the byte-stream lexer. Source bytes go in over the
// src channel in bursts; tokens come back on tok against a scoreboard fed by
// a behavioral lexer. Covers operators, whitespace, keywords, saturating
// numbers, back-pressure and the halt on an unknown byte.
// ----------------------------------------------------------------------------
module char_stream_tokenizer_core_tb;
  import cst_pkg::*;

  typedef enum logic [1:0] {
    RX_FREE   = 2'd0,
    RX_CHOPPY = 2'd1,
    RX_SLOW   = 2'd2
  } rx_mode_t;

  typedef enum logic [2:0] {
    CC_SPACE   = 3'd0,
    CC_DIGIT   = 3'd1,
    CC_IDSTART = 3'd2,
    CC_NUL     = 3'd3,
    CC_OP      = 3'd4,
    CC_BAD     = 3'd5
  } char_class_t;

  typedef struct {
    token_kind_t kind;
    logic [62:0] value;
    logic [15:0] start;
    logic [15:0] len;
    logic        last;
  } lexeme_t;

  localparam string OP_CHARS  = "+-*/=();{}";
  localparam string RET_WORD  = "return";
  localparam string LET_WORD  = "let";
  localparam logic [63:0] VMAX64 = {1'b0, VALUE_MAX};

  logic clk;
  logic rst;

  cst_in_if  src_if ();
  cst_out_if tok_if ();

  char_stream_tokenizer_core uut (
    .clk (clk),
    .rst (rst),
    .src (src_if),
    .tok (tok_if)
  );

  // Behavioral lexer state
  scan_mode_t  lex_mode;
  logic [63:0] num_acc;
  logic [15:0] tok_start;
  logic [15:0] tok_len;
  logic [15:0] lex_pos;
  logic        maybe_ret;
  logic        maybe_let;
  logic        lex_halted;

  lexeme_t expected_tokens[$];

  // Bench controls and statistics
  rx_mode_t    rx_mode;
  int          hold_len;
  int          hold_seq;
  bit          gaps_on;
  int          burst_left;
  int          bytes_sent;
  int          tokens_checked;
  int          pair_tokens;
  int          mismatches;
  logic [15:0] kinds_seen;

  string kw_forms[12] = '{"return", "let", "retur", "returns", "le", "lets",
                          "Return", "leT", "rEturn", "l", "r", "return_"};

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Character classes and the lexer model
  // --------------------------------------------------------------------------
  function automatic int op_index(logic [7:0] c);
    for (int i = 0; i < 10; i++)
      if (OP_CHARS[i] == c) return i;
    return -1;
  endfunction

  function automatic char_class_t classify(logic [7:0] c);
    if (c == 8'h00) return CC_NUL;
    if (c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A) return CC_SPACE;
    if (c >= 8'h30 && c <= 8'h39) return CC_DIGIT;
    if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F)
      return CC_IDSTART;
    if (op_index(c) >= 0) return CC_OP;
    return CC_BAD;
  endfunction

  function automatic void push_token(token_kind_t k, logic [62:0] v, logic [15:0] s,
                                     logic [15:0] l);
    lexeme_t t;
    t.kind  = k;
    t.value = v;
    t.start = s;
    t.len   = l;
    t.last  = 1'b0;
    expected_tokens.push_back(t);
  endfunction

  function automatic void open_token();
    tok_start = lex_pos;
    tok_len   = '0;
    num_acc   = '0;
    maybe_ret = 1'b1;
    maybe_let = 1'b1;
  endfunction

  function automatic void bump_len();
    if (tok_len < LEN_MAX) tok_len = tok_len + 16'd1;
  endfunction

  // Saturating decimal accumulate
  function automatic void acc_digit(logic [7:0] c);
    logic [63:0] d;
    d = 64'(c - 8'h30);
    if (num_acc > (VMAX64 - d) / 64'd10) num_acc = VMAX64;
    else num_acc = num_acc * 64'd10 + d;
  endfunction

  // Keyword candidates, checked against the byte at the current index
  function automatic void kw_track(logic [7:0] c);
    if (tok_len >= 16'd6 || RET_WORD[tok_len] != c) maybe_ret = 1'b0;
    if (tok_len >= 16'd3 || LET_WORD[tok_len] != c) maybe_let = 1'b0;
  endfunction

  function automatic void lex_reset();
    lex_mode   = MODE_IDLE;
    num_acc    = '0;
    tok_start  = '0;
    tok_len    = '0;
    lex_pos    = '0;
    maybe_ret  = 1'b1;
    maybe_let  = 1'b1;
    lex_halted = 1'b0;
  endfunction

  // Expected tokens for one accepted byte
  function automatic void lex_step(logic [7:0] c);
    int          made;
    char_class_t cl;
    token_kind_t k;
    if (lex_halted) return;
    made = 0;
    cl   = classify(c);
    if (lex_mode == MODE_NUM && cl == CC_DIGIT) begin
      acc_digit(c);
      bump_len();
    end else if (lex_mode == MODE_IDENT && (cl == CC_DIGIT || cl == CC_IDSTART)) begin
      kw_track(c);
      bump_len();
    end else begin
      // pending token goes out first
      if (lex_mode == MODE_NUM) begin
        push_token(KIND_INT, num_acc[62:0], tok_start, tok_len);
        made++;
      end else if (lex_mode == MODE_IDENT) begin
        k = KIND_IDENT;
        if (maybe_ret && tok_len == 16'd6) k = KIND_RETURN;
        else if (maybe_let && tok_len == 16'd3) k = KIND_LET;
        push_token(k, '0, tok_start, tok_len);
        made++;
      end
      lex_mode = MODE_IDLE;
      case (cl)
        CC_SPACE: ;
        CC_DIGIT: begin
          open_token();
          lex_mode = MODE_NUM;
          acc_digit(c);
          bump_len();
        end
        CC_IDSTART: begin
          open_token();
          lex_mode = MODE_IDENT;
          kw_track(c);
          bump_len();
        end
        CC_NUL: begin
          push_token(KIND_EOF, '0, lex_pos, '0);
          made++;
        end
        CC_OP: begin
          push_token(token_kind_t'(4'(int'(KIND_PLUS) + op_index(c))), '0, lex_pos, '0);
          made++;
        end
        default: begin
          push_token(KIND_ERROR, '0, lex_pos, '0);
          made++;
          lex_halted = 1'b1;
        end
      endcase
    end
    if (cl == CC_NUL) lex_pos = '0;
    else if (lex_pos < POS_MAX) lex_pos = lex_pos + 16'd1;
    if (made > 0) expected_tokens[expected_tokens.size() - 1].last = 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Sender: one item per call, bursts separated by random gaps
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap        = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 4);
      burst_left = $urandom_range(1, 16);
      src_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    src_if.valid <= 1'b1;
    src_if.ch    <= b;
    @(posedge clk);
    while (!src_if.ready) @(posedge clk);
    if (burst_left > 0) burst_left--;
    bytes_sent++;
    lex_step(b);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [7:0] rand_id_char(bit allow_digit);
    int r;
    r = $urandom_range(0, allow_digit ? 62 : 52);
    if (r < 26) return 8'h61 + 8'(r);
    if (r < 52) return 8'h41 + 8'(r - 26);
    if (r == 52) return 8'h5F;
    return 8'h30 + 8'(r - 53);
  endfunction

  function automatic logic [7:0] rand_legal_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 127));
    while (classify(b) == CC_BAD) b = 8'($urandom_range(0, 127));
    return b;
  endfunction

  // One random token shape, then zero to two whitespace bytes
  task automatic send_random_piece();
    int r;
    int n;
    logic [7:0] ws[4];
    ws = '{8'h20, 8'h09, 8'h0D, 8'h0A};
    r  = $urandom_range(0, 99);
    if (r < 30) begin
      send_byte(rand_id_char(1'b0));
      n = $urandom_range(0, 8);
      repeat (n) send_byte(rand_id_char(1'b1));
    end else if (r < 42) begin
      send_text(kw_forms[$urandom_range(0, 11)]);
    end else if (r < 67) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(18, 24) : $urandom_range(1, 4);
      repeat (n) send_byte(8'h30 + 8'($urandom_range(0, 9)));
    end else if (r < 87) begin
      send_byte(OP_CHARS[$urandom_range(0, 9)]);
    end else if (r < 92) begin
      send_byte(8'h00);
    end else begin
      n = $urandom_range(1, 3);
      repeat (n) send_byte(rand_legal_byte());
    end
    n = $urandom_range(0, 2);
    repeat (n) send_byte(ws[$urandom_range(0, 3)]);
  endtask

  task automatic send_random_bytes(input int count);
    int stop_at;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) send_random_piece();
  endtask

  // --------------------------------------------------------------------------
  // Receiver: stall pattern plus a counted hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    int          hold_seen;
    int          hold_left;
    logic [15:0] stall_pat;
    int          pat_left;
    hold_seen = 0;
    hold_left = 0;
    stall_pat = '1;
    pat_left  = 0;
    tok_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = hold_len;
        tok_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        tok_if.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_CHOPPY: begin
            if (pat_left == 0) begin
              stall_pat = 16'($urandom) | 16'($urandom);
              pat_left  = 16;
            end
            tok_if.ready <= stall_pat[0];
            stall_pat = stall_pat >> 1;
            pat_left--;
          end
          RX_SLOW: tok_if.ready <= ($urandom_range(0, 3) == 0);
          default: tok_if.ready <= 1'b1;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Token checker against the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    lexeme_t want;
    if (!rst && tok_if.valid && tok_if.ready) begin
      tokens_checked++;
      kinds_seen[tok_if.token_kind] = 1'b1;
      if (!tok_if.last_of_run) pair_tokens++;
      if (expected_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected token: kind %0d value %0d start %0d len %0d last %0b",
                   tok_if.token_kind, tok_if.int_value, tok_if.start_pos,
                   tok_if.token_length, tok_if.last_of_run);
      end else begin
        want = expected_tokens.pop_front();
        if (tok_if.token_kind !== want.kind || tok_if.int_value !== want.value ||
            tok_if.start_pos !== want.start || tok_if.token_length !== want.len ||
            tok_if.last_of_run !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("token %0d mismatch: got kind %0d value %0d start %0d len %0d last %0b",
                     tokens_checked, tok_if.token_kind, tok_if.int_value,
                     tok_if.start_pos, tok_if.token_length, tok_if.last_of_run);
            $display("  expected   kind %0d value %0d start %0d len %0d last %0b",
                     want.kind, want.value, want.start, want.len, want.last);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_operators_and_space();
    rx_mode <= RX_CHOPPY;
    send_text("+-*/=();{} \t\r\n");
    send_byte(8'h00);
  endtask

  task automatic test_keywords();
    send_text("return let retur returnx le lets Let _let x9_ r return(let;");
    send_byte(8'h00);
  endtask

  // Leading zeros, the largest value, overflow and digit/letter boundaries
  task automatic test_numbers();
    send_text("007 9223372036854775807 9223372036854775808 ");
    send_text("123456789012345678901234567890+7a a7 42");
    send_byte(8'h00);
  endtask

  // Three stretches: no idling, choppy receiver, slow receiver
  task automatic test_random_source();
    gaps_on = 1'b0;
    rx_mode <= RX_FREE;
    send_random_bytes(115);
    gaps_on = 1'b1;
    rx_mode <= RX_CHOPPY;
    send_random_bytes(115);
    rx_mode <= RX_SLOW;
    send_random_bytes(115);
  endtask

  // Receiver holds off while bytes keep coming, so the input stalls
  task automatic test_input_stall();
    gaps_on = 1'b0;
    rx_mode  <= RX_FREE;
    hold_len <= 300;
    hold_seq <= hold_seq + 1;
    send_random_bytes(80);
    gaps_on = 1'b1;
  endtask

  // Pending token plus error, then everything after is swallowed
  task automatic test_error_halt();
    logic [7:0] bad;
    rx_mode <= RX_CHOPPY;
    bad = 8'($urandom_range(0, 255));
    while (classify(bad) != CC_BAD) bad = 8'($urandom_range(0, 255));
    send_text("ab");
    send_byte(bad);
    repeat (48) send_byte(8'($urandom_range(0, 255)));
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst          = 1'b1;
    src_if.valid = 1'b0;
    src_if.ch    = 8'h00;
    rx_mode      = RX_FREE;
    hold_len     = 0;
    hold_seq     = 0;
    gaps_on      = 1'b1;
    burst_left   = 0;
    bytes_sent   = 0;
    tokens_checked = 0;
    pair_tokens  = 0;
    mismatches   = 0;
    kinds_seen   = '0;
    lex_reset();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_operators_and_space();
    test_keywords();
    test_numbers();
    test_random_source();
    test_input_stall();
    test_error_halt();

    src_if.valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);

    $display("run covered %0d source bytes and %0d tokens, %0d of them first of a pair",
             bytes_sent, tokens_checked, pair_tokens);
    $display("token kinds seen (bit per kind): %b, mismatches: %0d", kinds_seen, mismatches);
    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("char_stream_tokenizer_core_tb: done, clean");
    end else begin
      $display("char_stream_tokenizer_core_tb: done, errors");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #10000000;
    $display("timeout with %0d tokens still expected", expected_tokens.size());
    $display("char_stream_tokenizer_core_tb: done, errors");
    $finish;
  end

endmodule
